// ===== hw/rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants and codes for the bounded stack calculator.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int DEPTH_W     = 4;

  // Iteration counts of the shared adder
  localparam int MUL_STEPS   = VAL_W;
  localparam int DIV_STEPS   = VAL_W + FRAC_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Stream payload widths, padded to whole bytes
  localparam int IN_W        = 40;
  localparam int OUT_W       = 40;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/bsc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bounded_stack_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_calculator
// Bounded Q16.16 value stack with push, pop, add, sub, mul and div commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_ stream; each command returns exactly one
//   result transaction on the out_ stream (status, saturated, depth, top).
//   The block takes one command at a time: in_tready is high only while the
//   sequencer is idle. States from accept to result register:
//     push, pop to an empty stack, failures, unknown op: EXEC DONE
//     pop exposing an older entry (stack RAM read): EXEC POPRD DONE
//     add, sub: EXEC SAT DONE
//     mul (32 steps of the shared 33-bit adder): EXEC MUL FIX RND SAT DONE
//     div (48 restoring steps of the same adder): EXEC DIV FIX SAT DONE
//   The shared adder sets the throughput of mul and div.
//   One result is held in the output register; the next command is accepted
//   while it waits. If that next result is ready before out_tready, the
//   sequencer holds it and stays busy.
//   Reset (rst_n low, synchronous) empties the stack and drops any pending
//   result; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_stack_calculator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [bsc_pkg::IN_W-1:0] in_tdata,   // op[2:0], operand[34:3]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [bsc_pkg::OUT_W-1:0] out_tdata  // status[1:0], saturated[2],
                                               // depth[6:3], top_value[38:7]
);

  import bsc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_FIX   = 9'b000010000,
    S_RND   = 9'b000100000,
    S_SAT   = 9'b001000000,
    S_POPRD = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam logic signed [64:0] Q_MAX = 65'sd2147483647;
  localparam logic signed [64:0] Q_MIN = -65'sd2147483648;
  localparam logic signed [64:0] Q_HALF = 65'sd32768;

  state_t                state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [VAL_W-1:0]      opd_r, opd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VAL_W-1:0]      top_r, top_nxt;
  logic [VAL_W-1:0]      mag_r, mag_nxt;     // |a| for mul, |b| for div
  logic                  neg_r, neg_nxt;
  logic [VAL_W-1:0]      hi_r, hi_nxt;       // product high half / remainder
  logic [DIV_STEPS-1:0]  lo_r, lo_nxt;       // multiplier / quotient
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic signed [64:0]    fix_r, fix_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  sat_r, sat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic                  out_sat_r, out_sat_nxt;
  logic [DEPTH_W-1:0]    out_depth_r, out_depth_nxt;
  logic [VAL_W-1:0]      out_top_r, out_top_nxt;

  // shared adder
  logic [VAL_W:0]        add_x, add_y, add_s;
  logic                  add_sub;

  logic                  ram_we, ram_re;
  logic [PTR_W-1:0]      ram_waddr, ram_raddr;
  logic [VAL_W-1:0]      ram_wdata, ram_rdata;

  logic [CNT_W-1:0]      cnt_m1, cnt_m2;
  logic [CNT_W+DEPTH_W-1:0] cnt_ext;
  logic [VAL_W-1:0]      top_mag, opd_mag;
  logic [64:0]           fix_ext;
  logic                  qbit;
  logic                  in_fire;

  bsc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_top_r, out_depth_r, out_sat_r, out_status_r};

  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign cnt_m2  = cnt_r - CNT_W'(2);
  assign top_mag = top_r[VAL_W-1] ? (~top_r + VAL_W'(1)) : top_r;
  assign opd_mag = opd_r[VAL_W-1] ? (~opd_r + VAL_W'(1)) : opd_r;
  assign add_s   = add_x + (add_sub ? ~add_y : add_y) + {{VAL_W{1'b0}}, add_sub};
  assign qbit    = ~add_s[VAL_W];

  // Adder operand selection
  always_comb begin
    add_x   = {top_r[VAL_W-1], top_r};
    add_y   = {opd_r[VAL_W-1], opd_r};
    add_sub = (op_r == OP_SUB);
    case (state_r)
      S_MUL: begin
        add_x   = {1'b0, hi_r};
        add_y   = lo_r[0] ? {1'b0, mag_r} : '0;
        add_sub = 1'b0;
      end
      S_DIV: begin
        add_x   = {hi_r, lo_r[DIV_STEPS-1]};
        add_y   = {1'b0, mag_r};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (op_r == OP_MUL) begin
      fix_ext = {1'b0, hi_r, lo_r[VAL_W-1:0]};
    end else begin
      fix_ext = {{(65 - DIV_STEPS){1'b0}}, lo_r};
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    opd_nxt    = opd_r;
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    step_nxt   = step_r;
    fix_nxt    = fix_r;
    status_nxt = status_r;
    sat_nxt    = sat_r;
    ram_we     = 1'b0;
    ram_waddr  = cnt_r[PTR_W-1:0];
    ram_wdata  = opd_r;
    ram_re     = 1'b0;
    ram_raddr  = cnt_m2[PTR_W-1:0];

    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_sat_nxt    = out_sat_r;
    out_depth_nxt  = out_depth_r;
    out_top_nxt    = out_top_r;
    cnt_ext        = {{DEPTH_W{1'b0}}, cnt_r};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_tdata[2:0];
          opd_nxt   = in_tdata[VAL_W+2:3];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = ST_DONE;
        sat_nxt    = 1'b0;
        state_nxt  = S_DONE;
        case (op_r)
          OP_PUSH: begin
            if (cnt_r == CNT_W'(STACK_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              top_nxt = opd_r;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          OP_POP: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              cnt_nxt = cnt_m1;
              if (cnt_r > CNT_W'(1)) begin
                ram_re    = 1'b1;
                state_nxt = S_POPRD;
              end
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (cnt_r == CNT_W'(STACK_DEPTH)) begin
              status_nxt = ST_FULL;
            end else if (op_r == OP_DIV && opd_r == '0) begin
              status_nxt = ST_DIVZ;
            end else if (op_r == OP_MUL) begin
              mag_nxt   = top_mag;
              neg_nxt   = top_r[VAL_W-1] ^ opd_r[VAL_W-1];
              hi_nxt    = '0;
              lo_nxt    = {{FRAC_W{1'b0}}, opd_mag};
              step_nxt  = STEP_W'(MUL_STEPS - 1);
              state_nxt = S_MUL;
            end else if (op_r == OP_DIV) begin
              mag_nxt   = opd_mag;
              neg_nxt   = top_r[VAL_W-1] ^ opd_r[VAL_W-1];
              hi_nxt    = '0;
              lo_nxt    = {top_mag, {FRAC_W{1'b0}}};
              step_nxt  = STEP_W'(DIV_STEPS - 1);
              state_nxt = S_DIV;
            end else begin
              fix_nxt   = {{(65 - VAL_W - 1){add_s[VAL_W]}}, add_s};
              state_nxt = S_SAT;
            end
          end
          default: ;
        endcase
      end

      S_MUL: begin
        // shift-add: fold the adder carry into the product
        hi_nxt   = add_s[VAL_W:1];
        lo_nxt   = {{FRAC_W{1'b0}}, add_s[0], lo_r[VAL_W-1:1]};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_FIX;
        end
      end

      S_DIV: begin
        // restoring step, one quotient bit
        hi_nxt   = qbit ? add_s[VAL_W-1:0] : {hi_r[VAL_W-2:0], lo_r[DIV_STEPS-1]};
        lo_nxt   = {lo_r[DIV_STEPS-2:0], qbit};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_FIX;
        end
      end

      S_FIX: begin
        fix_nxt   = neg_r ? signed'(~fix_ext + 65'd1) : signed'(fix_ext);
        state_nxt = (op_r == OP_MUL) ? S_RND : S_SAT;
      end

      S_RND: begin
        // round to nearest, ties toward plus infinity
        fix_nxt   = (fix_r + Q_HALF) >>> FRAC_W;
        state_nxt = S_SAT;
      end

      S_SAT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m1[PTR_W-1:0];
        if (fix_r > Q_MAX) begin
          ram_wdata = Q_MAX[VAL_W-1:0];
          sat_nxt   = 1'b1;
        end else if (fix_r < Q_MIN) begin
          ram_wdata = Q_MIN[VAL_W-1:0];
          sat_nxt   = 1'b1;
        end else begin
          ram_wdata = fix_r[VAL_W-1:0];
        end
        top_nxt   = ram_wdata;
        state_nxt = S_DONE;
      end

      S_POPRD: begin
        top_nxt   = ram_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_sat_nxt    = sat_r;
          out_depth_nxt  = cnt_ext[DEPTH_W-1:0];
          out_top_nxt    = (cnt_r == '0) ? '0 : top_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    opd_r        <= opd_nxt;
    top_r        <= top_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    step_r       <= step_nxt;
    fix_r        <= fix_nxt;
    status_r     <= status_nxt;
    sat_r        <= sat_nxt;
    out_status_r <= out_status_nxt;
    out_sat_r    <= out_sat_nxt;
    out_depth_r  <= out_depth_nxt;
    out_top_r    <= out_top_nxt;
  end

endmodule
